@@ hw/rtl/one_bit_speaker_sample_player_defines.svh @@
// ---------------------------------------------------------------------------
// One-bit speaker sample player: assertion macros
// Shared check macros; they expand to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ONE_BIT_SPEAKER_SAMPLE_PLAYER_DEFINES_SVH
`define ONE_BIT_SPEAKER_SAMPLE_PLAYER_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset
`define OBSP_ASSERT(lbl, clk_s, rst_ns, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (prop)) else $error(msg);
// Condition that must never be seen outside reset
`define OBSP_ASSERT_NEVER(lbl, clk_s, rst_ns, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) !(cond)) else $error(msg);
`else
`define OBSP_ASSERT(lbl, clk_s, rst_ns, prop, msg)
`define OBSP_ASSERT_NEVER(lbl, clk_s, rst_ns, cond, msg)
`endif

`endif

@@ hw/rtl/obsp_pkg.sv @@
// ---------------------------------------------------------------------------
// One-bit speaker sample player: shared package
// Store sizes, field widths, item kinds and register indices.
// ---------------------------------------------------------------------------
package obsp_pkg;

  // Store sizes and mix lead
  localparam int BIT_STORE_BYTES = 8192;
  localparam int RING_DEPTH      = 4096;
  localparam int MIX_LEAD        = 100;

  localparam int BS_AW   = $clog2(BIT_STORE_BYTES);
  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int BIT_CAP = BIT_STORE_BYTES * 8;

  // Field widths
  localparam int LEN_W      = 17;
  localparam int POS_W      = 16;
  localparam int TICK_W     = 16;
  localparam int RING_W     = 32;
  localparam int ADDR_W     = 13;
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int GAIN_FRAC  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int MOD_CNT_W  = $clog2(LEN_W + 1);

  localparam int TICK_DIVIDER_RESET = 1024;

  // Item kinds
  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_LOAD  = 3'd1,
    KIND_MIX   = 3'd2,
    KIND_START = 3'd3,
    KIND_STOP  = 3'd4
  } kind_t;

  // Configuration register indices
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIX_MODE     = 3'd0,
    CFG_LOOP_ENABLE  = 3'd1,
    CFG_MUTE         = 3'd2,
    CFG_SAMPLE_LEN   = 3'd3,
    CFG_TICK_DIVIDER = 3'd4
  } cfg_idx_t;

endpackage

@@ hw/rtl/obsp_ram.sv @@
// ---------------------------------------------------------------------------
// One-bit speaker sample player: single-port RAM
// One access per cycle, read data registered, read returns the old entry.
// ---------------------------------------------------------------------------
module obsp_ram #(
  parameter  int DEPTH = 16,
  parameter  int WIDTH = 8,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/obsp_mod.sv @@
// ---------------------------------------------------------------------------
// One-bit speaker sample player: remainder unit
// Restoring remainder, one dividend bit per cycle, done pulses at the end.
// ---------------------------------------------------------------------------
module obsp_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [obsp_pkg::LEN_W-1:0]  dividend,
  input  logic [obsp_pkg::LEN_W-1:0]  divisor,
  output logic                        done,
  output logic [obsp_pkg::LEN_W-1:0]  remainder
);

  logic                           run_r;
  logic                           done_r;
  logic [obsp_pkg::MOD_CNT_W-1:0] cnt_r;
  logic [obsp_pkg::LEN_W-1:0]     dvd_r;
  logic [obsp_pkg::LEN_W-1:0]     dsr_r;
  logic [obsp_pkg::LEN_W-1:0]     rem_r;

  logic [obsp_pkg::LEN_W:0]       shifted;
  logic [obsp_pkg::LEN_W:0]       diff;
  logic [obsp_pkg::LEN_W-1:0]     rem_nxt;

  // Bring in the next dividend bit and subtract where it fits
  always_comb begin
    shifted = {rem_r, dvd_r[obsp_pkg::LEN_W-1]};
    diff    = shifted - {1'b0, dsr_r};
    rem_nxt = (shifted >= {1'b0, dsr_r}) ? diff[obsp_pkg::LEN_W-1:0]
                                         : shifted[obsp_pkg::LEN_W-1:0];
  end

  // Step the iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= obsp_pkg::MOD_CNT_W'(obsp_pkg::LEN_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == obsp_pkg::MOD_CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Hold operands and the partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[obsp_pkg::LEN_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

@@ hw/rtl/one_bit_speaker_sample_player.sv @@
// ---------------------------------------------------------------------------
// One-bit speaker sample player: top level
// Timer-driven 1-bit speaker player with a byte bit store and a mix ring.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on the out_ ports for exactly one cycle with out_valid high, and
// the receiver cannot hold it off. Load, stop, start in bit mode, ignored
// kinds, ticks that play nothing and ignored mix samples report in the next
// cycle and leave busy low. A bit-mode tick reads the bit store; a mix-mode
// tick reads the previous, then the current ring entry and clears the
// previous one on the one ring port; a mix sample accumulates into its
// entry, first waiting, if first_of_run is set, for the one-bit-per-cycle
// remainder unit that wraps play position plus lead into the ring length.
// After reset, and after a start in mix mode, the ring is cleared one entry
// per cycle over all RING_DEPTH (4096) entries with busy high; the start
// result is reported when that pass begins. Configuration writes are taken
// at any time but must only be made while the block is idle.
// ---------------------------------------------------------------------------
`include "one_bit_speaker_sample_player_defines.svh"

module one_bit_speaker_sample_player (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration
  input  logic                                  cfg_we,
  input  logic [obsp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [obsp_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Input items
  input  logic                                  start,
  output logic                                  busy,
  input  logic [2:0]                            in_kind,
  input  logic [obsp_pkg::ADDR_W-1:0]           in_byte_address,
  input  logic [7:0]                            in_byte_value,
  input  logic signed [obsp_pkg::SAMPLE_W-1:0]  in_sample_value,
  input  logic [obsp_pkg::GAIN_W-1:0]           in_gain,
  input  logic                                  in_first_of_run,
  // Results
  output logic                                  out_valid,
  output logic                                  out_speaker_bit,
  output logic                                  out_speaker_driven,
  output logic                                  out_chain_pulse,
  output logic [obsp_pkg::POS_W-1:0]            out_play_position,
  output logic                                  out_playing
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIT,
    ST_MRD1,
    ST_MWR,
    ST_MOD,
    ST_SRD,
    ST_SWR
  } state_t;

  // Configuration registers
  logic                                mix_mode_r;
  logic                                loop_enable_r;
  logic                                mute_r;
  logic [obsp_pkg::LEN_W-1:0]          sample_length_r;
  logic [obsp_pkg::TICK_W-1:0]         tick_divider_r;

  // Control state and its next values
  state_t                              state_r, state_nxt;
  logic [obsp_pkg::RING_AW-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [obsp_pkg::POS_W-1:0]          position_r, position_nxt;
  logic [obsp_pkg::RING_AW-1:0]        mwp_r, mwp_nxt;
  logic                                active_r, active_nxt;
  logic [obsp_pkg::TICK_W-1:0]         tick_cnt_r, tick_cnt_nxt;
  logic                                pulse_r, pulse_nxt;

  // Item payload held across the sequence
  logic [obsp_pkg::RING_AW-1:0]        p_r, p_nxt;
  logic [obsp_pkg::RING_AW-1:0]        prev_r, prev_nxt;
  logic [2:0]                          bit_sel_r, bit_sel_nxt;
  logic [obsp_pkg::RING_W-1:0]         k0_r, k0_nxt;
  logic signed [obsp_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic [obsp_pkg::RING_W-1:0]         q_r, q_nxt;
  logic [obsp_pkg::RING_AW-1:0]        wp_r, wp_nxt;

  // Registered outputs
  logic                                out_valid_r, out_valid_nxt;
  logic                                out_spk_r, out_spk_nxt;
  logic                                out_drv_r, out_drv_nxt;
  logic                                out_pulse_r, out_pulse_nxt;
  logic [obsp_pkg::POS_W-1:0]          out_pos_r, out_pos_nxt;
  logic                                out_playing_r, out_playing_nxt;

  // Memory ports
  logic                                ring_we;
  logic [obsp_pkg::RING_AW-1:0]        ring_addr;
  logic [obsp_pkg::RING_W-1:0]         ring_wdata;
  logic [obsp_pkg::RING_W-1:0]         ring_rdata;
  logic                                bit_we;
  logic [obsp_pkg::BS_AW-1:0]          bit_addr;
  logic [7:0]                          bit_rdata;

  // Remainder unit
  logic                                mod_start;
  logic                                mod_done;
  logic [obsp_pkg::LEN_W-1:0]          mod_rem;

  // Derived values
  logic                                accept;
  logic [obsp_pkg::LEN_W-1:0]          len_cap;
  logic [obsp_pkg::LEN_W-1:0]          len_c;
  logic [obsp_pkg::LEN_W-1:0]          len_m1;
  logic [obsp_pkg::POS_W-1:0]          p_c;
  logic [obsp_pkg::LEN_W-1:0]          next_wide;
  logic [obsp_pkg::POS_W-1:0]          next_c;
  logic [obsp_pkg::RING_AW-1:0]        p_ring;
  logic [obsp_pkg::RING_AW-1:0]        prev_c;
  logic                                play_c;
  logic [obsp_pkg::LEN_W-1:0]          tick_inc;
  logic                                wrap_c;
  logic [obsp_pkg::RING_AW-1:0]        mwp_c;
  logic [obsp_pkg::LEN_W-1:0]          lead_sum;
  logic [obsp_pkg::LEN_W-1:0]          wp_inc;
  logic [31:0]                         p_wide;
  logic signed [obsp_pkg::PROD_W-1:0]  prod_c;
  logic [obsp_pkg::PROD_W-1:0]         biased;
  logic [obsp_pkg::RING_W-1:0]         q_c;
  logic [obsp_pkg::RING_W-1:0]         k1_c;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Effective length and tick arithmetic
  always_comb begin
    len_cap   = mix_mode_r ? obsp_pkg::LEN_W'(obsp_pkg::RING_DEPTH)
                           : obsp_pkg::LEN_W'(obsp_pkg::BIT_CAP);
    len_c     = (sample_length_r < len_cap) ? sample_length_r : len_cap;
    len_m1    = len_c - 1'b1;
    p_c       = (obsp_pkg::LEN_W'(position_r) < len_c) ? position_r : '0;
    next_wide = obsp_pkg::LEN_W'(p_c) + 1'b1;
    next_c    = (next_wide >= len_c) ? '0 : next_wide[obsp_pkg::POS_W-1:0];
    p_ring    = p_c[obsp_pkg::RING_AW-1:0];
    prev_c    = (p_c == '0) ? len_m1[obsp_pkg::RING_AW-1:0] : p_ring - 1'b1;
    play_c    = active_r && (len_c != '0);
    tick_inc  = obsp_pkg::LEN_W'(tick_cnt_r) + 1'b1;
    wrap_c    = (tick_inc >= obsp_pkg::LEN_W'(tick_divider_r));
    mwp_c     = (obsp_pkg::LEN_W'(mwp_r) < len_c) ? mwp_r : '0;
    lead_sum  = obsp_pkg::LEN_W'(position_r) + obsp_pkg::LEN_W'(obsp_pkg::MIX_LEAD);
    wp_inc    = obsp_pkg::LEN_W'(wp_r) + 1'b1;
    p_wide    = 32'(p_c);
  end

  // Scale the sample and truncate towards zero
  always_comb begin
    prod_c = in_sample_value * $signed({1'b0, in_gain});
    biased = prod_r + {{(obsp_pkg::PROD_W - obsp_pkg::GAIN_FRAC){1'b0}},
                       {obsp_pkg::GAIN_FRAC{prod_r[obsp_pkg::PROD_W-1]}}};
    q_c    = obsp_pkg::RING_W'($signed(biased[obsp_pkg::PROD_W-1:obsp_pkg::GAIN_FRAC]));
    k1_c   = (p_r == prev_r) ? '0 : ring_rdata;
  end

  // Next-state logic
  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    position_nxt    = position_r;
    mwp_nxt         = mwp_r;
    active_nxt      = active_r;
    tick_cnt_nxt    = tick_cnt_r;
    pulse_nxt       = pulse_r;
    p_nxt           = p_r;
    prev_nxt        = prev_r;
    bit_sel_nxt     = bit_sel_r;
    k0_nxt          = k0_r;
    prod_nxt        = prod_r;
    q_nxt           = q_r;
    wp_nxt          = wp_r;
    out_valid_nxt   = 1'b0;
    out_spk_nxt     = 1'b0;
    out_drv_nxt     = 1'b0;
    out_pulse_nxt   = 1'b0;
    ring_we         = 1'b0;
    ring_addr       = '0;
    ring_wdata      = '0;
    bit_we          = 1'b0;
    bit_addr        = p_wide[3 +: obsp_pkg::BS_AW];
    mod_start       = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        // Sweep the ring to zero
        ring_we     = 1'b1;
        ring_addr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == obsp_pkg::RING_AW'(obsp_pkg::RING_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (obsp_pkg::kind_t'(in_kind))
            obsp_pkg::KIND_TICK: begin
              tick_cnt_nxt = wrap_c ? '0 : tick_inc[obsp_pkg::TICK_W-1:0];
              pulse_nxt    = wrap_c;
              if (play_c) begin
                position_nxt = next_c;
                if (!mix_mode_r) begin
                  // Fetch the byte holding the current bit
                  bit_sel_nxt = p_c[2:0];
                  if (!loop_enable_r && (next_c == '0)) begin
                    active_nxt = 1'b0;
                  end
                  state_nxt = ST_BIT;
                end else begin
                  // Fetch the previous ring entry first
                  ring_addr = prev_c;
                  p_nxt     = p_ring;
                  prev_nxt  = prev_c;
                  state_nxt = ST_MRD1;
                end
              end else begin
                out_valid_nxt = 1'b1;
                out_pulse_nxt = wrap_c;
              end
            end
            obsp_pkg::KIND_LOAD: begin
              bit_we        = (32'(in_byte_address) < obsp_pkg::BIT_STORE_BYTES);
              bit_addr      = obsp_pkg::BS_AW'(in_byte_address);
              out_valid_nxt = 1'b1;
            end
            obsp_pkg::KIND_MIX: begin
              if (mix_mode_r && (len_c != '0)) begin
                prod_nxt = prod_c;
                if (in_first_of_run) begin
                  mod_start = 1'b1;
                  state_nxt = ST_MOD;
                end else begin
                  wp_nxt    = mwp_c;
                  state_nxt = ST_SRD;
                end
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            obsp_pkg::KIND_START: begin
              position_nxt  = '0;
              tick_cnt_nxt  = '0;
              active_nxt    = 1'b1;
              out_valid_nxt = 1'b1;
              if (mix_mode_r) begin
                clr_cnt_nxt = '0;
                state_nxt   = ST_CLEAR;
              end
            end
            obsp_pkg::KIND_STOP: begin
              if (!mix_mode_r) begin
                active_nxt = 1'b0;
              end
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_BIT: begin
        // Pick the bit out of the fetched byte
        out_valid_nxt = 1'b1;
        out_spk_nxt   = bit_rdata[bit_sel_r];
        out_drv_nxt   = !mute_r;
        out_pulse_nxt = pulse_r;
        state_nxt     = ST_IDLE;
      end
      ST_MRD1: begin
        // Hold the previous entry, fetch the current one
        k0_nxt    = ring_rdata;
        ring_addr = p_r;
        state_nxt = ST_MWR;
      end
      ST_MWR: begin
        // Clear the previous entry and compare
        ring_we       = 1'b1;
        ring_addr     = prev_r;
        out_valid_nxt = 1'b1;
        out_spk_nxt   = ($signed(k1_c) > $signed(k0_r));
        out_drv_nxt   = !mute_r;
        out_pulse_nxt = pulse_r;
        state_nxt     = ST_IDLE;
      end
      ST_MOD: begin
        // Wait for the wrapped write position
        if (mod_done) begin
          wp_nxt    = mod_rem[obsp_pkg::RING_AW-1:0];
          state_nxt = ST_SRD;
        end
      end
      ST_SRD: begin
        ring_addr = wp_r;
        q_nxt     = q_c;
        state_nxt = ST_SWR;
      end
      ST_SWR: begin
        // Accumulate into the entry and advance the write position
        ring_we       = 1'b1;
        ring_addr     = wp_r;
        ring_wdata    = ring_rdata + q_r;
        mwp_nxt       = (wp_inc >= len_c) ? '0 : wp_inc[obsp_pkg::RING_AW-1:0];
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_pos_nxt     = position_nxt;
    out_playing_nxt = active_nxt;
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_cnt_r     <= '0;
      position_r    <= '0;
      mwp_r         <= '0;
      active_r      <= 1'b0;
      tick_cnt_r    <= '0;
      pulse_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      out_spk_r     <= 1'b0;
      out_drv_r     <= 1'b0;
      out_pulse_r   <= 1'b0;
      out_pos_r     <= '0;
      out_playing_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      position_r    <= position_nxt;
      mwp_r         <= mwp_nxt;
      active_r      <= active_nxt;
      tick_cnt_r    <= tick_cnt_nxt;
      pulse_r       <= pulse_nxt;
      out_valid_r   <= out_valid_nxt;
      out_spk_r     <= out_spk_nxt;
      out_drv_r     <= out_drv_nxt;
      out_pulse_r   <= out_pulse_nxt;
      out_pos_r     <= out_pos_nxt;
      out_playing_r <= out_playing_nxt;
    end
  end

  // Hold item payload
  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    prev_r    <= prev_nxt;
    bit_sel_r <= bit_sel_nxt;
    k0_r      <= k0_nxt;
    prod_r    <= prod_nxt;
    q_r       <= q_nxt;
    wp_r      <= wp_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_mode_r      <= 1'b0;
      loop_enable_r   <= 1'b1;
      mute_r          <= 1'b0;
      sample_length_r <= '0;
      tick_divider_r  <= obsp_pkg::TICK_W'(obsp_pkg::TICK_DIVIDER_RESET);
    end else if (cfg_we) begin
      case (obsp_pkg::cfg_idx_t'(cfg_index))
        obsp_pkg::CFG_MIX_MODE:     mix_mode_r      <= cfg_data[0];
        obsp_pkg::CFG_LOOP_ENABLE:  loop_enable_r   <= cfg_data[0];
        obsp_pkg::CFG_MUTE:         mute_r          <= cfg_data[0];
        obsp_pkg::CFG_SAMPLE_LEN:   sample_length_r <= cfg_data[obsp_pkg::LEN_W-1:0];
        obsp_pkg::CFG_TICK_DIVIDER: tick_divider_r  <= cfg_data[obsp_pkg::TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Mix ring
  obsp_ram #(
    .DEPTH (obsp_pkg::RING_DEPTH),
    .WIDTH (obsp_pkg::RING_W)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .addr  (ring_addr),
    .wdata (ring_wdata),
    .rdata (ring_rdata)
  );

  // Bit store
  obsp_ram #(
    .DEPTH (obsp_pkg::BIT_STORE_BYTES),
    .WIDTH (8)
  ) u_bit_store (
    .clk   (clk),
    .we    (bit_we),
    .addr  (bit_addr),
    .wdata (in_byte_value),
    .rdata (bit_rdata)
  );

  // Wrap of play position plus lead into the ring length
  obsp_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (lead_sum),
    .divisor   (len_c),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign out_valid          = out_valid_r;
  assign out_speaker_bit    = out_spk_r;
  assign out_speaker_driven = out_drv_r;
  assign out_chain_pulse    = out_pulse_r;
  assign out_play_position  = out_pos_r;
  assign out_playing        = out_playing_r;

  // Checks
  `OBSP_ASSERT(a_result_has_cause, clk, rst_n, out_valid |-> ($past(start) || $past(busy)), "result without an item")
  `OBSP_ASSERT_NEVER(a_no_ring_write_idle, clk, rst_n, ring_we && (state_r == ST_IDLE), "ring written while idle")
  `OBSP_ASSERT(a_mod_done_waited, clk, rst_n, mod_done |-> (state_r == ST_MOD), "remainder done with nobody waiting")

endmodule

@@ dv/obsp_result_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// One-bit speaker sample player: result checker
// Watches the register port and the item channel, keeps its own copy of the
// player state, works out the status each accepted item should report and
// compares every result strobe with the oldest outstanding status.
// ---------------------------------------------------------------------------
module obsp_result_checker
  import obsp_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        start,
  input  logic                        busy,
  input  logic [2:0]                  in_kind,
  input  logic [ADDR_W-1:0]           in_byte_address,
  input  logic [7:0]                  in_byte_value,
  input  logic signed [SAMPLE_W-1:0]  in_sample_value,
  input  logic [GAIN_W-1:0]           in_gain,
  input  logic                        in_first_of_run,
  input  logic                        out_valid,
  input  logic                        out_speaker_bit,
  input  logic                        out_speaker_driven,
  input  logic                        out_chain_pulse,
  input  logic [POS_W-1:0]            out_play_position,
  input  logic                        out_playing,
  output int                          fault_count,
  output int                          outstanding
);

  typedef struct packed {
    logic             spk;
    logic             drv;
    logic             pulse;
    logic [POS_W-1:0] pos;
    logic             playing;
  } player_status_t;

  // Shadow of the player state and registers
  logic [7:0]        store_shadow [BIT_STORE_BYTES];
  logic [RING_W-1:0] ring_shadow  [RING_DEPTH];
  logic [POS_W-1:0]  play_pos;
  logic [15:0]       mix_wr_pos;
  logic              is_playing;
  logic [TICK_W-1:0] tick_cnt;
  logic              mix_mode_r;
  logic              loop_r;
  logic              mute_r;
  logic [LEN_W-1:0]  length_r;
  logic [TICK_W-1:0] divider_r;

  player_status_t status_fifo[$];

  task automatic report_fault(string what, int got, int want);
    fault_count++;
    $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Effective length: sample_length clamped to the store of the active mode
  function automatic int play_length();
    int cap;
    cap = mix_mode_r ? RING_DEPTH : BIT_CAP;
    return (int'(length_r) < cap) ? int'(length_r) : cap;
  endfunction

  // Apply one item to the shadow state and return the status it reports
  task automatic advance_player(input logic [2:0] kind, input logic [ADDR_W-1:0] addr,
                                input logic [7:0] bval,
                                input logic signed [SAMPLE_W-1:0] sample,
                                input logic [GAIN_W-1:0] gain, input logic first,
                                output player_status_t res);
    int len;
    int p;
    int nxt;
    int prv;
    int wp;
    int cnt;
    logic signed [RING_W-1:0] k0;
    logic signed [RING_W-1:0] k1;
    longint prod;
    longint q;
    len = play_length();
    res = '0;
    case (kind)
      KIND_TICK: begin
        if (is_playing && len != 0) begin
          p = (int'(play_pos) < len) ? int'(play_pos) : 0;
          nxt = p + 1;
          if (nxt >= len) nxt = 0;
          if (!mix_mode_r) begin
            res.spk = store_shadow[p >> 3][p % 8];
            if (!loop_r && nxt == 0) is_playing = 1'b0;
          end else begin
            // previous entry is read, then cleared, then the current one read
            prv = (p == 0) ? len - 1 : p - 1;
            k0 = ring_shadow[prv];
            ring_shadow[prv] = '0;
            k1 = ring_shadow[p];
            res.spk = (k1 > k0);
          end
          play_pos = nxt[POS_W-1:0];
          res.drv = !mute_r;
        end
        // the divider counts every tick, playing or not
        cnt = int'(tick_cnt) + 1;
        if (cnt >= int'(divider_r)) begin
          cnt = 0;
          res.pulse = 1'b1;
        end
        tick_cnt = cnt[TICK_W-1:0];
      end
      KIND_LOAD: begin
        store_shadow[addr] = bval;
      end
      KIND_MIX: begin
        if (mix_mode_r && len != 0) begin
          prod = longint'(sample) * longint'(gain);
          q = prod / (longint'(1) << GAIN_FRAC);
          if (first) wp = (int'(play_pos) + MIX_LEAD) % len;
          else wp = (int'(mix_wr_pos) < len) ? int'(mix_wr_pos) : 0;
          ring_shadow[wp] = ring_shadow[wp] + q[RING_W-1:0];
          wp = wp + 1;
          if (wp >= len) wp = 0;
          mix_wr_pos = wp[15:0];
        end
      end
      KIND_START: begin
        play_pos = '0;
        tick_cnt = '0;
        is_playing = 1'b1;
        if (mix_mode_r) foreach (ring_shadow[i]) ring_shadow[i] = '0;
      end
      KIND_STOP: begin
        if (!mix_mode_r) is_playing = 1'b0;
      end
      default: ;
    endcase
    res.pos = play_pos;
    res.playing = is_playing;
  endtask

  always @(posedge clk) begin : watch
    player_status_t got;
    player_status_t want;
    if (!rst_n) begin
      foreach (ring_shadow[i]) ring_shadow[i] = '0;
      play_pos = '0;
      mix_wr_pos = '0;
      is_playing = 1'b0;
      tick_cnt = '0;
      mix_mode_r = 1'b0;
      loop_r = 1'b1;
      mute_r = 1'b0;
      length_r = '0;
      divider_r = TICK_W'(TICK_DIVIDER_RESET);
      status_fifo.delete();
    end else begin
      // Compare the result transfer with the oldest outstanding status
      if (out_valid) begin
        got = '{out_speaker_bit, out_speaker_driven, out_chain_pulse,
                out_play_position, out_playing};
        if (status_fifo.size() == 0) begin
          report_fault("surplus result, outstanding count", 1, 0);
        end else begin
          want = status_fifo.pop_front();
          if (got.spk != want.spk) report_fault("speaker_bit", got.spk, want.spk);
          if (got.drv != want.drv) report_fault("speaker_driven", got.drv, want.drv);
          if (got.pulse != want.pulse) report_fault("chain_pulse", got.pulse, want.pulse);
          if (got.pos != want.pos) report_fault("play_position", got.pos, want.pos);
          if (got.playing != want.playing) report_fault("playing", got.playing, want.playing);
        end
      end
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIX_MODE:     mix_mode_r = cfg_data[0];
          CFG_LOOP_ENABLE:  loop_r = cfg_data[0];
          CFG_MUTE:         mute_r = cfg_data[0];
          CFG_SAMPLE_LEN:   length_r = cfg_data[LEN_W-1:0];
          CFG_TICK_DIVIDER: divider_r = cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      // Predict the status of an accepted item
      if (start && !busy) begin
        advance_player(in_kind, in_byte_address, in_byte_value, in_sample_value,
                       in_gain, in_first_of_run, want);
        status_fifo.push_back(want);
      end
    end
    outstanding <= status_fifo.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// One-bit speaker sample player: testbench top
// Drives a directed set of items and then random phases in both play modes
// under several register settings, with random start gaps; the result
// checker beside the block compares every result transfer.
// ---------------------------------------------------------------------------
module tb_top;
  import obsp_pkg::*;

  localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
  localparam int ITEMS_PER_PHASE = 50;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [2:0]                  in_kind = '0;
  logic [ADDR_W-1:0]           in_byte_address = '0;
  logic [7:0]                  in_byte_value = '0;
  logic signed [SAMPLE_W-1:0]  in_sample_value = '0;
  logic [GAIN_W-1:0]           in_gain = '0;
  logic                        in_first_of_run = 1'b0;
  logic                        out_valid;
  logic                        out_speaker_bit;
  logic                        out_speaker_driven;
  logic                        out_chain_pulse;
  logic [POS_W-1:0]            out_play_position;
  logic                        out_playing;
  int                          fault_count;
  int                          outstanding;

  // Stimulus bookkeeping: keep every bit-store byte a tick could read written
  bit   loaded [BIT_STORE_BYTES];
  int   fill_next = 0;
  int   tick_span = 0;
  logic mix_now = 1'b0;
  logic idle_on = 1'b1;

  one_bit_speaker_sample_player u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_byte_address    (in_byte_address),
    .in_byte_value      (in_byte_value),
    .in_sample_value    (in_sample_value),
    .in_gain            (in_gain),
    .in_first_of_run    (in_first_of_run),
    .out_valid          (out_valid),
    .out_speaker_bit    (out_speaker_bit),
    .out_speaker_driven (out_speaker_driven),
    .out_chain_pulse    (out_chain_pulse),
    .out_play_position  (out_play_position),
    .out_playing        (out_playing)
  );

  obsp_result_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_byte_address    (in_byte_address),
    .in_byte_value      (in_byte_value),
    .in_sample_value    (in_sample_value),
    .in_gain            (in_gain),
    .in_first_of_run    (in_first_of_run),
    .out_valid          (out_valid),
    .out_speaker_bit    (out_speaker_bit),
    .out_speaker_driven (out_speaker_driven),
    .out_chain_pulse    (out_chain_pulse),
    .out_play_position  (out_play_position),
    .out_playing        (out_playing),
    .fault_count        (fault_count),
    .outstanding        (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hold start low for a random burst now and then, raise it and wait for the transfer
  task automatic push_item(input logic [2:0] kind, input logic [ADDR_W-1:0] addr,
                           input logic [7:0] bval, input logic [SAMPLE_W-1:0] sample,
                           input logic [GAIN_W-1:0] gain, input logic first);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start           <= 1'b1;
    in_kind         <= kind;
    in_byte_address <= addr;
    in_byte_value   <= bval;
    in_sample_value <= sample;
    in_gain         <= gain;
    in_first_of_run <= first;
    do @(posedge clk); while (busy);
    case (kind)
      KIND_LOAD:  loaded[addr] = 1'b1;
      KIND_START: tick_span = 0;
      KIND_TICK:  if (tick_span < 65535) tick_span++;
      default: ;
    endcase
  endtask

  task automatic push_rand(input logic [2:0] kind, input logic first);
    push_item(kind, ADDR_W'($urandom_range(0, BIT_STORE_BYTES - 1)), 8'($urandom),
              SAMPLE_W'($urandom), GAIN_W'($urandom), first);
  endtask

  // In bit mode, load any byte up to the furthest position reachable first
  task automatic play_tick();
    while (!mix_now && fill_next <= (tick_span >> 3)) begin
      if (!loaded[fill_next])
        push_item(KIND_LOAD, ADDR_W'(fill_next), 8'($urandom), SAMPLE_W'($urandom),
                  GAIN_W'($urandom), 1'($urandom));
      fill_next++;
    end
    push_rand(KIND_TICK, 1'($urandom));
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic write_regs(input logic mode, input logic loop_en, input logic mute_en,
                            input logic [LEN_W-1:0] len, input logic [TICK_W-1:0] div);
    put_reg(CFG_MIX_MODE, CFG_DATA_W'(mode));
    put_reg(CFG_LOOP_ENABLE, CFG_DATA_W'(loop_en));
    put_reg(CFG_MUTE, CFG_DATA_W'(mute_en));
    put_reg(CFG_SAMPLE_LEN, CFG_DATA_W'(len));
    put_reg(CFG_TICK_DIVIDER, CFG_DATA_W'(div));
    cfg_we  <= 1'b0;
    mix_now = mode;
    @(posedge clk);
  endtask

  // Drop start and wait until every status has arrived and the block is idle
  task automatic settle();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int   counted;
    int   roll;
    int   mix_starts;
    logic last_mix;
    logic first;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    // Bit mode, no looping: idle tick, play to the wrap and stop there
    write_regs(1'b0, 1'b0, 1'b0, 17'd4, 16'd1);
    push_item(KIND_LOAD, '0, 8'hA5, 16'h7FFF, 16'hFFFF, 1'b1);
    push_item(KIND_LOAD, ADDR_W'(BIT_STORE_BYTES - 1), 8'h00, 16'h8000, 16'h0000, 1'b0);
    play_tick();
    push_rand(KIND_START, 1'b0);
    repeat (5) play_tick();
    push_rand(KIND_STOP, 1'b0);
    push_rand(KIND_MIX, 1'b1);
    for (int k = 0; k < 3; k++) push_rand(KIND_UNUSED_FIRST + 3'(k), 1'b0);
    settle();

    // Mix mode, ring length one, divider zero, muted; stop is ignored here
    write_regs(1'b1, 1'b1, 1'b1, 17'd1, 16'd0);
    push_rand(KIND_START, 1'b0);
    push_item(KIND_MIX, '0, '0, 16'h8000, 16'hFFFF, 1'b1);
    push_item(KIND_MIX, '0, '0, 16'h7FFF, 16'hFFFF, 1'b0);
    play_tick();
    play_tick();
    push_rand(KIND_STOP, 1'b0);
    settle();

    // Zero length: ticks play nothing, mix samples are dropped
    write_regs(1'b1, 1'b0, 1'b0, 17'd0, 16'd2);
    play_tick();
    push_rand(KIND_MIX, 1'b1);
    play_tick();
    settle();

    // Random phases over a spread of settings; no start gaps in the last two
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_regs(1'b0, 1'b1, 1'b0, 17'd40, 16'd3);
        1: write_regs(1'b1, 1'b0, 1'b0, 17'd4096, 16'd65535);
        2: write_regs(1'b0, 1'b0, 1'b1, 17'd65536, 16'd1);
        3: write_regs(1'b1, 1'b1, 1'b0, 17'd200, 16'd0);
        4: write_regs(1'b0, 1'b1, 1'b0, 17'd131071, 16'd7);
        5: write_regs(1'b1, 1'($urandom), 1'($urandom), 17'($urandom_range(2, 300)),
                      16'($urandom_range(1, 40)));
        6: write_regs(1'b0, 1'($urandom), 1'($urandom), 17'($urandom_range(1, 100)),
                      16'($urandom_range(1, 20)));
        default: write_regs(1'b1, 1'($urandom), 1'($urandom), 17'($urandom_range(1, 4500)),
                            16'($urandom));
      endcase
      idle_on = (ph < 6);
      push_rand(KIND_START, 1'b0);
      counted = 0;
      mix_starts = 0;
      last_mix = 1'b0;
      while (counted < ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        if (mix_now) begin
          // Mostly runs of samples opened by a first-of-run item, between ticks
          if (roll < 45) begin
            play_tick();
            last_mix = 1'b0;
          end else if (roll < 85) begin
            first = !last_mix || $urandom_range(0, 9) == 0;
            push_rand(KIND_MIX, first);
            last_mix = 1'b1;
          end else if (roll < 90) begin
            push_rand(KIND_LOAD, 1'($urandom));
          end else if (roll < 95) begin
            push_rand(KIND_STOP, 1'($urandom));
          end else if (roll < 97 && mix_starts < 2) begin
            push_rand(KIND_START, 1'($urandom));
            mix_starts++;
          end else begin
            push_rand(KIND_UNUSED_FIRST + 3'($urandom_range(0, 2)), 1'($urandom));
            counted--;
          end
        end else begin
          if (roll < 55) begin
            play_tick();
          end else if (roll < 75) begin
            push_rand(KIND_LOAD, 1'($urandom));
          end else if (roll < 83) begin
            push_rand(KIND_START, 1'($urandom));
          end else if (roll < 90) begin
            push_rand(KIND_STOP, 1'($urandom));
          end else if (roll < 95) begin
            push_rand(KIND_MIX, 1'($urandom));
            counted--;
          end else begin
            push_rand(KIND_UNUSED_FIRST + 3'($urandom_range(0, 2)), 1'($urandom));
            counted--;
          end
        end
        counted++;
      end
      settle();
    end

    repeat (30) @(posedge clk);
    if (fault_count == 0) begin
      $display("one_bit_speaker_sample_player: match");
    end else begin
      $display("one_bit_speaker_sample_player: mismatch");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #4_000_000;
    $display("one_bit_speaker_sample_player: mismatch");
    $finish;
  end

endmodule
